FILE: hw/rtl/chrm_pkg.sv
package chrm_pkg;

  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;
  localparam int VREF_W = 13;
  localparam int DIST_W = 33;

  // serial divider: widest dividend is feedback * vref (29 bits)
  localparam int DIV_NW = 29;
  localparam int DIV_DW = 16;

  localparam logic [IDX_W-1:0] CFG_TH_HIGH = 3'd0;
  localparam logic [IDX_W-1:0] CFG_TH_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MAGNETS = 3'd2;
  localparam logic [IDX_W-1:0] CFG_WINDOW  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_VREF    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_FSCALE  = 3'd5;

  localparam logic [15:0] TH_HIGH_RST = 16'd40000;
  localparam logic [15:0] TH_LOW_RST  = 16'd20000;
  localparam logic [7:0]  MAGNETS_RST = 8'd1;
  localparam logic [15:0] WINDOW_RST  = 16'd50;
  localparam logic [12:0] VREF_RST    = 13'd3300;
  localparam logic [15:0] FSCALE_RST  = 16'd65535;

  localparam logic [5:0]  RPM_SCALE = 6'd60;
  localparam logic [2:0]  FILT_OLD  = 3'd7;
  localparam logic [1:0]  FILT_NEW  = 2'd3;
  localparam logic [3:0]  FILT_DIV  = 4'd10;

  // distance per revolution 1700 / 1000 reduced to tenths
  localparam logic [4:0]  DIST_NUM = 5'd17;

  // x / 10 == (x * TENTH_RECIP) >> TENTH_SHIFT for any 32-bit x
  localparam logic [31:0] TENTH_RECIP = 32'hCCCC_CCCD;
  localparam int          TENTH_SHIFT = 35;

  typedef enum logic [1:0] {
    OP_RPM  = 2'd0,
    OP_FILT = 2'd1,
    OP_MV   = 2'd2,
    OP_DIST = 2'd3
  } op_t;

  typedef struct packed {
    logic step;
    logic div_start;
    op_t  op;
    logic capture;
    logic emit;
  } chrm_cmd_t;

  typedef struct packed {
    logic win_end;
    logic div_done;
    logic out_free;
  } chrm_sts_t;

endpackage

FILE: hw/rtl/chrm_div.sv
module chrm_div #(
  parameter int NW = 43,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    diff     = trial - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/chrm_ctrl.sv
module chrm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  chrm_pkg::chrm_sts_t sts,
  output chrm_pkg::chrm_cmd_t cmd
);
  import chrm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd.step      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.op        = op_r;
    cmd.capture   = 1'b0;
    cmd.emit      = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.step = in_valid;
        if (in_valid && sts.win_end) begin
          state_nxt = S_LOAD;
          op_nxt    = OP_RPM;
        end
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          case (op_r)
            OP_RPM: begin
              op_nxt    = OP_FILT;
              state_nxt = S_LOAD;
            end
            OP_FILT: begin
              op_nxt    = OP_MV;
              state_nxt = S_LOAD;
            end
            OP_MV: begin
              op_nxt    = OP_DIST;
              state_nxt = S_LOAD;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_RPM;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

FILE: hw/rtl/chrm_dp.sv
module chrm_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [chrm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [chrm_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [15:0]                   in_cadence_sample,
  input  logic [15:0]                   in_feedback_sample,
  input  chrm_pkg::chrm_cmd_t           cmd,
  output chrm_pkg::chrm_sts_t           sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_filtered_rpm,
  output logic                          out_rotating,
  output logic [31:0]                   out_total_revolutions,
  output logic [31:0]                   out_elapsed_seconds,
  output logic [chrm_pkg::VREF_W-1:0]   out_feedback_mv,
  output logic [chrm_pkg::DIST_W-1:0]   out_distance
);
  import chrm_pkg::*;

  // configuration
  logic [15:0]       th_high_r;
  logic [15:0]       th_low_r;
  logic [7:0]        magnets_r;
  logic [15:0]       window_r;
  logic [VREF_W-1:0] vref_r;
  logic [15:0]       fscale_r;

  // block state
  logic                   active_r;
  logic [15:0]            pulses_r;
  logic [31:0]            revs_r;
  logic [15:0]            count_r;
  logic [15:0]            rpm_r;
  logic [31:0]            windows_r;
  logic [SAMPLE_BITS-1:0] feedback_r;

  // window-end results
  logic [15:0]       meas_r;
  logic [VREF_W-1:0] mv_r;
  logic [DIST_W-1:0] dist_r;
  logic              out_valid_r;

  logic [15:0]        cad;
  logic [15:0]        win_eff;
  logic [7:0]         mag_eff;
  logic [15:0]        fs_eff;
  logic [DIV_NW-1:0]  div_a;
  logic [DIV_DW-1:0]  div_b;
  logic [DIV_NW-1:0]  quo;
  logic               div_done;
  logic               div_start;

  // divide by ten: reciprocal multiply, then quotient or distance
  logic               k_start;
  logic [31:0]        k_x;
  logic [1:0]         k_stage_r;
  logic               k_done_r;
  logic [31:0]        k_x_r;
  logic [63:0]        k_prod_r;
  logic [DIST_W-1:0]  k_res_r;
  logic [31:0]        k_q;
  logic [3:0]         k_rem;
  logic [3:0]         k_tail;

  assign cad     = 16'(in_cadence_sample[SAMPLE_BITS-1:0]);
  assign win_eff = (window_r == '0) ? 16'd1 : window_r;
  assign mag_eff = (magnets_r == '0) ? 8'd1 : magnets_r;
  assign fs_eff  = (fscale_r == '0) ? 16'd1 : fscale_r;

  assign sts.win_end  = (17'(count_r) + 17'd1) >= 17'(win_eff);
  assign sts.div_done = div_done || k_done_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign div_start = cmd.div_start && (cmd.op inside {OP_RPM, OP_MV});
  assign k_start   = cmd.div_start && (cmd.op inside {OP_FILT, OP_DIST});

  // divider operand select
  always_comb begin
    if (cmd.op == OP_RPM) begin
      div_a = DIV_NW'(pulses_r) * DIV_NW'(RPM_SCALE);
      div_b = DIV_DW'(mag_eff);
    end else begin
      div_a = DIV_NW'(feedback_r) * DIV_NW'(vref_r);
      div_b = fs_eff;
    end
  end

  chrm_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  assign k_x   = (cmd.op == OP_FILT) ?
                 32'(rpm_r) * 32'(FILT_OLD) + 32'(meas_r) * 32'(FILT_NEW) : revs_r;
  assign k_q   = 32'(k_prod_r >> TENTH_SHIFT);
  assign k_rem = 4'(k_x_r - k_q * 32'(FILT_DIV));

  // 17 * r / 10 for a remainder below ten
  always_comb begin
    case (k_rem)
      4'd0:    k_tail = 4'd0;
      4'd1:    k_tail = 4'd1;
      4'd2:    k_tail = 4'd3;
      4'd3:    k_tail = 4'd5;
      4'd4:    k_tail = 4'd6;
      4'd5:    k_tail = 4'd8;
      4'd6:    k_tail = 4'd10;
      4'd7:    k_tail = 4'd11;
      4'd8:    k_tail = 4'd13;
      4'd9:    k_tail = 4'd15;
      default: k_tail = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_stage_r <= '0;
      k_done_r  <= 1'b0;
    end else begin
      k_stage_r <= {k_stage_r[0], k_start};
      k_done_r  <= k_stage_r[1];
    end
    if (k_start) begin
      k_x_r <= k_x;
    end
    if (k_stage_r[0]) begin
      k_prod_r <= 64'(k_x_r) * 64'(TENTH_RECIP);
    end
    if (k_stage_r[1]) begin
      k_res_r <= (cmd.op == OP_FILT) ? DIST_W'(k_q) :
                 DIST_W'(k_q) * DIST_W'(DIST_NUM) + DIST_W'(k_tail);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_high_r   <= TH_HIGH_RST;
      th_low_r    <= TH_LOW_RST;
      magnets_r   <= MAGNETS_RST;
      window_r    <= WINDOW_RST;
      vref_r      <= VREF_RST;
      fscale_r    <= FSCALE_RST;
      active_r    <= 1'b0;
      pulses_r    <= '0;
      revs_r      <= '0;
      count_r     <= '0;
      rpm_r       <= '0;
      windows_r   <= '0;
      feedback_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TH_HIGH: th_high_r <= cfg_wdata;
          CFG_TH_LOW:  th_low_r  <= cfg_wdata;
          CFG_MAGNETS: magnets_r <= cfg_wdata[7:0];
          CFG_WINDOW:  window_r  <= cfg_wdata;
          CFG_VREF:    vref_r    <= cfg_wdata[VREF_W-1:0];
          CFG_FSCALE:  fscale_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.step) begin
        if (!active_r && (cad > th_high_r)) begin
          if (pulses_r != 16'hFFFF) begin
            pulses_r <= pulses_r + 16'd1;
          end
          revs_r   <= revs_r + 32'd1;
          active_r <= 1'b1;
        end else if (active_r && (cad < th_low_r)) begin
          active_r <= 1'b0;
        end
        feedback_r <= in_feedback_sample[SAMPLE_BITS-1:0];
        count_r    <= sts.win_end ? 16'd0 : count_r + 16'd1;
      end

      if (cmd.capture && (cmd.op == OP_FILT)) begin
        rpm_r <= k_res_r[15:0];
      end

      if (cmd.emit) begin
        pulses_r    <= '0;
        windows_r   <= windows_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (cmd.capture) begin
      case (cmd.op)
        OP_RPM:  meas_r <= (quo[DIV_NW-1:16] != '0) ? 16'hFFFF : quo[15:0];
        OP_MV:   mv_r   <= (quo > DIV_NW'(vref_r)) ? vref_r : quo[VREF_W-1:0];
        OP_DIST: dist_r <= k_res_r;
        default: ;
      endcase
    end

    if (cmd.emit) begin
      out_filtered_rpm      <= rpm_r;
      out_rotating          <= (rpm_r != '0);
      out_total_revolutions <= revs_r;
      out_elapsed_seconds   <= windows_r + 32'd1;
      out_feedback_mv       <= mv_r;
      out_distance          <= dist_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/cadence_hysteresis_rpm_meter_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    cadence_sample, feedback_sample
// out      output     out_valid / out_ready  rpm, rotating, revs, seconds, mv, distance
// cfg      input      cfg_wr_en              cfg_index, cfg_wdata
//
// a sample pair that does not close a window is taken while in_ready stays high
// a window-closing pair runs two divisions on the serial divider, one quotient bit
// per cycle, and two divisions by ten through a reciprocal multiply that registers
// the operand, then the product, then the result before the result is loaded
// rst_n is synchronous; configuration takes its reset values
// a pending result waits in the output register while new samples are taken;
// the next window end holds until that result is taken
module cadence_hysteresis_rpm_meter_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [chrm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [chrm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_cadence_sample,
  input  logic [15:0]                 in_feedback_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_filtered_rpm,
  output logic                        out_rotating,
  output logic [31:0]                 out_total_revolutions,
  output logic [31:0]                 out_elapsed_seconds,
  output logic [chrm_pkg::VREF_W-1:0] out_feedback_mv,
  output logic [chrm_pkg::DIST_W-1:0] out_distance
);
  import chrm_pkg::*;

  chrm_cmd_t cmd;
  chrm_sts_t sts;

  chrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chrm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_cadence_sample     (in_cadence_sample),
    .in_feedback_sample    (in_feedback_sample),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_filtered_rpm      (out_filtered_rpm),
    .out_rotating          (out_rotating),
    .out_total_revolutions (out_total_revolutions),
    .out_elapsed_seconds   (out_elapsed_seconds),
    .out_feedback_mv       (out_feedback_mv),
    .out_distance          (out_distance)
  );

endmodule
